// ----- rtl/core/event_ring_proximity_query_unit_defines.svh -----
// Assertion macros shared by the event ring proximity query unit.
`ifndef EVENT_RING_PROXIMITY_QUERY_UNIT_DEFINES_SVH
`define EVENT_RING_PROXIMITY_QUERY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every clock edge outside reset.
`define ERPQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("event ring assertion failed");

// Checks that a condition never becomes true outside reset.
`define ERPQ_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("event ring forbidden condition seen");

`else

`define ERPQ_ASSERT(label, clk, rst_n, prop)
`define ERPQ_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/erpq_pkg.sv -----
// Shared types and constants of the event ring proximity query unit.
package erpq_pkg;

	localparam int FUNC_W    = 2;
	localparam int TIME_W    = 32;
	localparam int RADIUS_W  = 16;
	localparam int R2_W      = 2 * RADIUS_W;
	localparam int MAX_OUT_W = 7;

	localparam logic [FUNC_W-1:0] FUNC_EMIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Time window of one query: lower stamp bound, current time and age limit.
	typedef struct packed {
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] max_age;
	} time_win_t;

endpackage

// ----- rtl/core/erpq_ring_mem.sv -----
// Event ring storage: one write port, one read port with registered data.
module erpq_ring_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds while the scan pipeline is stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/erpq_match.sv -----
// Three-stage filter that tests one ring entry against the query window and sphere.
module erpq_match #(
	parameter int COORD_BITS   = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [3*COORD_BITS+PAYLOAD_BITS+erpq_pkg::TIME_W-1:0] ent_in,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] cz,
	input  logic [erpq_pkg::R2_W-1:0] r2,
	input  erpq_pkg::time_win_t       win,
	output logic                      out_valid,
	output logic                      out_match,
	output logic [3*COORD_BITS+PAYLOAD_BITS+erpq_pkg::TIME_W-1:0] ent_out,
	output logic                      busy
);

	import erpq_pkg::*;

	localparam int DATA_LO = TIME_W;
	localparam int Z_LO    = DATA_LO + PAYLOAD_BITS;
	localparam int Y_LO    = Z_LO + COORD_BITS;
	localparam int X_LO    = Y_LO + COORD_BITS;
	localparam int ENT_W   = X_LO + COORD_BITS;
	localparam int DIF_W   = COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int SUM_W   = SQ_W + 2;
	localparam int CMP_W   = (SUM_W > R2_W) ? SUM_W : R2_W;

	logic signed [COORD_BITS-1:0] ex, ey, ez;
	logic [TIME_W-1:0]            stamp, age;
	logic signed [DIF_W-1:0]      dx_d, dy_d, dz_d;
	logic                         tok_d;

	logic                         v_s1, v_s2, v_s3;
	logic signed [DIF_W-1:0]      dx_s1, dy_s1, dz_s1;
	logic                         tok_s1, tok_s2;
	logic [ENT_W-1:0]             ent_s1, ent_s2, ent_s3;
	logic signed [2*DIF_W-1:0]    px, py, pz;
	logic [SQ_W-1:0]              sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0]             sum;
	logic                         hit_s3;

	always_comb begin
		ex    = ent_in[X_LO +: COORD_BITS];
		ey    = ent_in[Y_LO +: COORD_BITS];
		ez    = ent_in[Z_LO +: COORD_BITS];
		stamp = ent_in[0 +: TIME_W];
		age   = win.now - stamp;
		tok_d = (stamp >= win.since) && (age <= win.max_age);
		dx_d  = DIF_W'(ex) - DIF_W'(cx);
		dy_d  = DIF_W'(ey) - DIF_W'(cy);
		dz_d  = DIF_W'(ez) - DIF_W'(cz);
	end

	// Each square is below two to the power SQ_W, so the low bits carry it exactly.
	always_comb begin
		px  = dx_s1 * dx_s1;
		py  = dy_s1 * dy_s1;
		pz  = dz_s1 * dz_s1;
		sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dx_d;
			dy_s1  <= dy_d;
			dz_s1  <= dz_d;
			tok_s1 <= tok_d;
			ent_s1 <= ent_in;
			sqx_s2 <= px[SQ_W-1:0];
			sqy_s2 <= py[SQ_W-1:0];
			sqz_s2 <= pz[SQ_W-1:0];
			tok_s2 <= tok_s1;
			ent_s2 <= ent_s1;
			hit_s3 <= tok_s2 && (CMP_W'(sum) <= CMP_W'(r2));
			ent_s3 <= ent_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_match = hit_s3;
	assign ent_out   = ent_s3;
	assign busy      = v_s1 | v_s2 | v_s3;

endmodule

// ----- rtl/core/event_ring_proximity_query_unit.sv -----
// Top level of the event ring proximity query unit: control, ring pointers and result output.
//
// The unit keeps the last RING_DEPTH events (origin, payload, time stamp) in one
// synchronous memory. An emit or a clear gives no result. A query walks the valid
// entries from newest to oldest, one memory read per cycle while the result side does
// not stall, through a three-stage filter (time window, coordinate differences, squares,
// and the compare of the squared distance with the squared radius). It reports up to
// max_out matching entries, limited to RING_DEPTH, and always ends with an item that
// has is_last set; if nothing matched, that item has hit clear and all fields zero. A
// query reads no entry when the ring is empty or max_out is zero; it stops reading early
// once the limit is reached, and a stall on the result side holds the scan. New input
// transfers are taken only between queries. Because each reported entry is held back
// until the next match or the end of the scan decides whether it is the last one,
// results leave one match behind the scan. The ring needs no clearing pass: a clear
// only resets the head pointer and the entry count, and only counted entries are ever
// read. The max_age register has its own channel; a running scan compares against its
// current value, so the user must write it only while no query is in flight; the unit
// itself does not enforce this.

`include "event_ring_proximity_query_unit_defines.svh"

module event_ring_proximity_query_unit #(
	parameter int RING_DEPTH   = 64,
	parameter int PAYLOAD_BITS = 32,
	parameter int COORD_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration channel (max_age).
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [erpq_pkg::TIME_W-1:0]       cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [erpq_pkg::FUNC_W-1:0]       func,
	input  logic signed [COORD_BITS-1:0]      pos_x,
	input  logic signed [COORD_BITS-1:0]      pos_y,
	input  logic signed [COORD_BITS-1:0]      pos_z,
	input  logic [PAYLOAD_BITS-1:0]           event_data,
	input  logic [erpq_pkg::RADIUS_W-1:0]     radius,
	input  logic [erpq_pkg::TIME_W-1:0]       since,
	input  logic [erpq_pkg::TIME_W-1:0]       now,
	input  logic [erpq_pkg::MAX_OUT_W-1:0]    max_out,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              is_last,
	output logic signed [COORD_BITS-1:0]      out_x,
	output logic signed [COORD_BITS-1:0]      out_y,
	output logic signed [COORD_BITS-1:0]      out_z,
	output logic [PAYLOAD_BITS-1:0]           out_data,
	output logic [erpq_pkg::TIME_W-1:0]       out_stamp
);

	import erpq_pkg::*;

	localparam int IDX_W   = $clog2(RING_DEPTH);
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int LIM_W   = (CNT_W > MAX_OUT_W) ? CNT_W : MAX_OUT_W;
	localparam int DATA_LO = TIME_W;
	localparam int Z_LO    = DATA_LO + PAYLOAD_BITS;
	localparam int Y_LO    = Z_LO + COORD_BITS;
	localparam int X_LO    = Y_LO + COORD_BITS;
	localparam int ENT_W   = X_LO + COORD_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     valid_count_q;
	logic [TIME_W-1:0]    max_age_q;

	// Query context, captured when the query is taken.
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [R2_W-1:0]      r2_q;
	logic [TIME_W-1:0]    since_q, now_q;
	logic [CNT_W-1:0]     scan_cnt_q, issue_cnt_q, limit_q, hits_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic                 rd_v_q;

	// Held-back match and output register.
	logic                 pend_valid_q;
	logic [ENT_W-1:0]     pend_ent_q;
	logic                 out_valid_q, out_hit_q, out_last_q;
	logic [ENT_W-1:0]     out_ent_q;

	logic                 in_xfer, do_emit, do_clear, do_query;
	logic                 adv, issue_more, issue, drained, take_hit, load_out;
	logic [LIM_W-1:0]     max_out_w;
	logic [CNT_W-1:0]     limit_d;
	logic [ENT_W-1:0]     wr_ent, rd_ent, m_ent;
	logic                 m_valid, m_match, m_busy;
	time_win_t            win;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign do_emit   = in_xfer && (func == FUNC_EMIT);
	assign do_query  = in_xfer && (func == FUNC_QUERY);
	assign do_clear  = in_xfer && (func == FUNC_CLEAR);

	// The whole scan pipeline moves only when the output register can take a result.
	assign adv        = !out_valid_q || out_ready;
	assign issue_more = (issue_cnt_q != scan_cnt_q) && (hits_q != limit_q);
	assign issue      = (state_q == ST_SCAN) && adv && issue_more;
	assign drained    = !issue_more && !rd_v_q && !m_busy;
	assign take_hit   = adv && m_valid && m_match && (hits_q != limit_q);
	assign load_out   = (take_hit && pend_valid_q) || ((state_q == ST_FLUSH) && adv);

	// A max_out above the ring depth saturates at the depth.
	always_comb begin
		max_out_w = LIM_W'(max_out);
		if (max_out_w > LIM_W'(RING_DEPTH)) begin
			limit_d = CNT_W'(RING_DEPTH);
		end else begin
			limit_d = CNT_W'(max_out_w);
		end
	end

	assign wr_ent = {pos_x, pos_y, pos_z, event_data, now};

	always_comb begin
		win.since   = since_q;
		win.now     = now_q;
		win.max_age = max_age_q;
	end

	erpq_ring_mem #(
		.DEPTH (RING_DEPTH),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_emit),
		.wr_addr (head_q),
		.wr_data (wr_ent),
		.rd_en   (issue),
		.rd_addr (rd_addr_q),
		.rd_data (rd_ent)
	);

	erpq_match #(
		.COORD_BITS   (COORD_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (rd_v_q),
		.ent_in    (rd_ent),
		.cx        (cx_q),
		.cy        (cy_q),
		.cz        (cz_q),
		.r2        (r2_q),
		.win       (win),
		.out_valid (m_valid),
		.out_match (m_match),
		.ent_out   (m_ent),
		.busy      (m_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= TIME_W'(5000);
		end else if (cfg_valid && cfg_ready) begin
			max_age_q <= cfg_data;
		end
	end

	// Ring pointers: emit writes at the head, clear forgets every entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			valid_count_q <= '0;
		end else if (do_clear) begin
			head_q        <= '0;
			valid_count_q <= '0;
		end else if (do_emit) begin
			head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
			if (valid_count_q != CNT_W'(RING_DEPTH)) begin
				valid_count_q <= valid_count_q + CNT_W'(1);
			end
		end
	end

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_cnt_q   <= '0;
			issue_cnt_q  <= '0;
			limit_q      <= '0;
			hits_q       <= '0;
			rd_addr_q    <= '0;
			rd_v_q       <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				rd_v_q <= issue;
			end
			if (issue) begin
				issue_cnt_q <= issue_cnt_q + CNT_W'(1);
				rd_addr_q   <= (rd_addr_q == '0) ? LAST_IDX : rd_addr_q - IDX_W'(1);
			end
			if (take_hit) begin
				hits_q       <= hits_q + CNT_W'(1);
				pend_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_query) begin
						state_q     <= ST_SCAN;
						scan_cnt_q  <= valid_count_q;
						issue_cnt_q <= '0;
						limit_q     <= limit_d;
						hits_q      <= '0;
						rd_addr_q   <= (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);
					end
				end
				ST_SCAN: begin
					if (drained) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						state_q      <= ST_IDLE;
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_query) begin
			cx_q    <= pos_x;
			cy_q    <= pos_y;
			cz_q    <= pos_z;
			r2_q    <= R2_W'(radius) * R2_W'(radius);
			since_q <= since;
			now_q   <= now;
		end
		if (take_hit) begin
			pend_ent_q <= m_ent;
		end
	end

	// Output register: a new match releases the one held before it; the flush releases
	// the held match as the last item, or the empty terminator when there is none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_FLUSH) begin
				out_hit_q  <= pend_valid_q;
				out_last_q <= 1'b1;
				out_ent_q  <= pend_valid_q ? pend_ent_q : '0;
			end else begin
				out_hit_q  <= 1'b1;
				out_last_q <= 1'b0;
				out_ent_q  <= pend_ent_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign is_last   = out_last_q;
	assign out_x     = out_ent_q[X_LO +: COORD_BITS];
	assign out_y     = out_ent_q[Y_LO +: COORD_BITS];
	assign out_z     = out_ent_q[Z_LO +: COORD_BITS];
	assign out_data  = out_ent_q[DATA_LO +: PAYLOAD_BITS];
	assign out_stamp = out_ent_q[0 +: TIME_W];

	// The scan pipeline is empty whenever new input is taken.
	`ERPQ_ASSERT(a_idle_drained, clk, arst_n, (state_q == ST_IDLE) |-> (!rd_v_q && !m_busy))
	// A query never reports more entries than its limit.
	`ERPQ_ASSERT(a_hits_bounded, clk, arst_n, hits_q <= limit_q)
	// Every flush puts a last item into the output register.
	`ERPQ_ASSERT(a_flush_last, clk, arst_n,
		(state_q == ST_FLUSH && adv) |=> (out_valid_q && out_last_q))
	// The entry count saturates at the ring depth.
	`ERPQ_ASSERT(a_count_bounded, clk, arst_n, valid_count_q <= CNT_W'(RING_DEPTH))
	// A held match never survives past the end of its query.
	`ERPQ_ASSERT_NEVER(a_pend_idle, clk, arst_n, pend_valid_q && (state_q == ST_IDLE))

endmodule
